### src/gkst_pkg.sv
// Shared types and constants for the GUID key set table.
`default_nettype none
package gkst_pkg;

  localparam int KEY_W     = 128;
  localparam int HALF_W    = 64;
  localparam int FUNC_W    = 2;
  localparam int SLOT_W    = 4;
  localparam int IN_DATA_W = 128;
  localparam int OUT_W     = 8;

  localparam logic [FUNC_W-1:0] OP_FIND   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the incoming word, restart the scan
    logic scan;    // issue a read at the scan address and advance
    logic commit;  // apply the update and load the output register
  } gkst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_rd;   // scan address is at the last slot
    logic out_free;  // output register can take a result this cycle
  } gkst_stat_t;

endpackage
`default_nettype wire

### src/guid_key_set_table_top.sv
// Top level of the GUID key set table: stream ports, controller and datapath.
// Each word passes through a scan that reads every slot of the key memory, a read
//   drain, and a commit that loads the output register when it can take a result.
// A word is taken only after the previous one is committed; the single read port of
//   the key memory sets the scan length. A new word is taken while a result waits.
// Reset (rst, synchronous, active high) empties the set by clearing all valid
//   bits; key memory contents are not cleared and need no clearing pass.
`default_nettype none
module guid_key_set_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst,
  // input stream
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire [127:0]  s_tdata,   // [63:0] guid_high, [127:64] guid_low
  input  wire [1:0]    s_tuser,   // [1:0] func
  // result stream
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [7:0]   m_tdata    // [0] hit, [1] success, [2] table_full,
                                  // [6:3] slot, [7] zero
);
  import gkst_pkg::*;

  gkst_cmd_t  cmd;
  gkst_stat_t stat;
  logic [KEY_W-1:0] key;

  // key as one 128-bit word: upper half on top
  assign key = {s_tdata[HALF_W-1:0], s_tdata[IN_DATA_W-1:HALF_W]};

  gkst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gkst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (s_tuser),
    .in_key    (key),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

### src/gkst_ctrl.sv
// Sequencer for one operation: accept, scan, drain, commit.
`default_nettype none
module gkst_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  gkst_pkg::gkst_stat_t stat,
  output gkst_pkg::gkst_cmd_t  cmd
);
  import gkst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd.load   = accept;
    cmd.scan   = (state == ST_SCAN);
    cmd.commit = (state == ST_FINISH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_SCAN;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (stat.last_rd) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### src/gkst_dp.sv
// Key memory, valid bits, scan compare and result register.
`default_nettype none
module gkst_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  gkst_pkg::gkst_cmd_t                  cmd,
  output gkst_pkg::gkst_stat_t                 stat,
  input  wire [gkst_pkg::FUNC_W-1:0]           in_func,
  input  wire [gkst_pkg::KEY_W-1:0]            in_key,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [gkst_pkg::OUT_W-1:0]           out_data
);
  import gkst_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]       rd_data;
  logic [TABLE_DEPTH-1:0] valid;

  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [IDX_W-1:0]  rd_addr;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  logic             wr_en;
  logic             del_en;
  logic             res_hit;
  logic             res_success;
  logic             res_full;
  logic [IDX_W-1:0] res_idx;
  logic [EXT_W-1:0] res_ext;

  assign stat.last_rd  = (rd_addr == IDX_W'(TABLE_DEPTH - 1));
  assign stat.out_free = !out_valid || out_ready;

  // result of the finished scan
  always_comb begin
    res_hit     = match_found;
    res_success = 1'b0;
    res_full    = 1'b0;
    res_idx     = match_found ? match_idx : '0;
    wr_en       = 1'b0;
    del_en      = 1'b0;
    unique case (func)
      OP_FIND: begin
        res_success = match_found;
      end
      OP_ADD: begin
        if (!match_found) begin
          if (free_found) begin
            wr_en       = 1'b1;
            res_success = 1'b1;
            res_idx     = free_idx;
          end else begin
            res_full = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (match_found) begin
          del_en      = 1'b1;
          res_success = 1'b1;
        end
      end
      default: begin
        res_success = 1'b0;
      end
    endcase
    res_ext = EXT_W'(res_idx);
  end

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      key_mem[free_idx] <= key;
    end
    rd_data <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit) begin
      if (wr_en) begin
        valid[free_idx] <= 1'b1;
      end else if (del_en) begin
        valid[match_idx] <= 1'b0;
      end
    end
  end

  // operand capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      key  <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr     <= '0;
      cmp_vld     <= 1'b0;
      cmp_idx     <= '0;
      match_found <= 1'b0;
      match_idx   <= '0;
      free_found  <= 1'b0;
      free_idx    <= '0;
    end else begin
      cmp_vld <= cmd.scan;
      cmp_idx <= rd_addr;
      if (cmd.load) begin
        rd_addr     <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else begin
        if (cmd.scan && !stat.last_rd) begin
          rd_addr <= rd_addr + 1'b1;
        end
        if (cmp_vld) begin
          if (!match_found && valid[cmp_idx] && (rd_data == key)) begin
            match_found <= 1'b1;
            match_idx   <= cmp_idx;
          end
          if (!free_found && !valid[cmp_idx]) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {1'b0, res_ext[SLOT_W-1:0], res_full, res_success, res_hit};
    end
  end

endmodule
`default_nettype wire
